### rtl/core/morse_phrase_blinker_unit_defines.svh
// Assertion macros shared by the morse phrase blinker RTL.
`ifndef MORSE_PHRASE_BLINKER_UNIT_DEFINES_SVH
`define MORSE_PHRASE_BLINKER_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
`define MPB_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("%m: assertion failed");
`define MPB_ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("%m: assertion failed");
`else
`define MPB_ASSERT(label, clk, rst, prop)
`define MPB_ASSERT_ALWAYS(label, clk, prop)
`endif

`endif

### rtl/core/mpb_pkg.sv
// Shared types, constants and the character-to-pattern lookup of the Morse blinker.
package mpb_pkg;

   localparam int PHRASE_DEPTH_DEFAULT = 128;
   localparam int PATTERN_WIDTH = 19;
   localparam int SYMBOL_COUNT = 36;

   typedef enum logic [1:0] {
      REQ_WRITE   = 2'd0,
      REQ_RESTART = 2'd1,
      REQ_TICK    = 2'd2
   } req_kind_type;

   typedef enum logic [1:0] {
      CSR_DIVIDER_PERIOD = 2'd0,
      CSR_LED_INDEX      = 2'd1,
      CSR_ON_COLOR       = 2'd2,
      CSR_END_COLOR      = 2'd3
   } csr_index_type;

   localparam logic [7:0] CHAR_NUL     = 8'h00;
   localparam logic [7:0] CHAR_UPPER_A = 8'h41;
   localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
   localparam logic [7:0] CHAR_LOWER_A = 8'h61;
   localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;
   localparam logic [7:0] CHAR_DIGIT_0 = 8'h30;
   localparam logic [7:0] CHAR_DIGIT_9 = 8'h39;
   localparam logic [7:0] CASE_OFFSET  = 8'h20;
   localparam logic [5:0] DIGIT_BASE   = 6'd26;

   localparam logic [PATTERN_WIDTH-1:0] MARK_BITS = 19'h00001;
   localparam logic [4:0] MARK_LEN = 5'd7;
   localparam logic [4:0] GAP_LEN  = 5'd4;

   // Bit k of an entry is unit slot k; letters A to Z, then digits 0 to 9.
   localparam logic [PATTERN_WIDTH-1:0] SYM_BITS [SYMBOL_COUNT] = '{
      19'h0001D, 19'h00157, 19'h005D7, 19'h00057, 19'h00001, 19'h00175,
      19'h00177, 19'h00055, 19'h00005, 19'h01DDD, 19'h001D7, 19'h0015D,
      19'h00077, 19'h00017, 19'h00777, 19'h005DD, 19'h01D77, 19'h0005D,
      19'h00015, 19'h00007, 19'h00075, 19'h001D5, 19'h001DD, 19'h00757,
      19'h01DD7, 19'h00577, 19'h77777, 19'h1DDDD, 19'h07775, 19'h01DD5,
      19'h00755, 19'h00155, 19'h00557, 19'h01577, 19'h05777, 19'h17777
   };

   localparam logic [4:0] SYM_LEN [SYMBOL_COUNT] = '{
      5'd8,  5'd12, 5'd14, 5'd10, 5'd4,  5'd12, 5'd12, 5'd10, 5'd6,
      5'd16, 5'd12, 5'd12, 5'd10, 5'd8,  5'd14, 5'd14, 5'd16, 5'd10,
      5'd8,  5'd6,  5'd10, 5'd12, 5'd12, 5'd14, 5'd16, 5'd14,
      5'd22, 5'd20, 5'd18, 5'd16, 5'd14, 5'd12, 5'd14, 5'd16, 5'd18, 5'd20
   };

   typedef struct packed {
      logic [PATTERN_WIDTH-1:0] bits;
      logic [4:0]               len;
   } pattern_type;

   typedef struct packed {
      logic emit;
      logic lit;
      logic marker;
   } unit_type;

   function automatic pattern_type char_pattern(logic [7:0] code, logic marker);
      pattern_type result;
      logic [7:0]  upper;
      logic [7:0]  offset;
      result.bits = '0;
      result.len  = GAP_LEN;
      upper = (code >= CHAR_LOWER_A && code <= CHAR_LOWER_Z) ? code - CASE_OFFSET : code;
      offset = '0;
      if (marker) begin
         result.bits = MARK_BITS;
         result.len  = MARK_LEN;
      end else if (upper >= CHAR_UPPER_A && upper <= CHAR_UPPER_Z) begin
         offset = upper - CHAR_UPPER_A;
         result.bits = SYM_BITS[offset[5:0]];
         result.len  = SYM_LEN[offset[5:0]];
      end else if (upper >= CHAR_DIGIT_0 && upper <= CHAR_DIGIT_9) begin
         offset = upper - CHAR_DIGIT_0;
         result.bits = SYM_BITS[DIGIT_BASE + offset[5:0]];
         result.len  = SYM_LEN[DIGIT_BASE + offset[5:0]];
      end
      return result;
   endfunction

endpackage

### rtl/core/mpb_phrase_mem.sv
// Phrase character memory with post-reset clearing sweep and a shadow of position zero.
module mpb_phrase_mem #(
   parameter int PHRASE_DEPTH = mpb_pkg::PHRASE_DEPTH_DEFAULT,
   parameter int ADDR_WIDTH   = $clog2(PHRASE_DEPTH)
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  wr_en,
   input  logic [ADDR_WIDTH-1:0] wr_addr,
   input  logic [7:0]            wr_data,
   input  logic [ADDR_WIDTH-1:0] rd_addr,
   output logic [7:0]            rd_data,
   output logic [7:0]            first_char,
   output logic                  clear_busy
);

   localparam logic [ADDR_WIDTH-1:0] LAST_ADDR = ADDR_WIDTH'(PHRASE_DEPTH - 1);

   logic [7:0]            store_ff [PHRASE_DEPTH];
   logic [7:0]            rd_data_ff;
   logic [7:0]            first_char_ff;
   logic [ADDR_WIDTH-1:0] clear_addr_ff;
   logic                  clear_busy_ff;

   logic                  mem_we;
   logic [ADDR_WIDTH-1:0] mem_waddr;
   logic [7:0]            mem_wdata;

   assign mem_we    = clear_busy_ff || wr_en;
   assign mem_waddr = clear_busy_ff ? clear_addr_ff : wr_addr;
   assign mem_wdata = clear_busy_ff ? mpb_pkg::CHAR_NUL : wr_data;

   // A write in the same cycle is forwarded so the read data never lags a transfer.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         store_ff[mem_waddr] <= mem_wdata;
      end
      if (mem_we && mem_waddr == rd_addr) begin
         rd_data_ff <= mem_wdata;
      end else begin
         rd_data_ff <= store_ff[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clear_busy_ff <= 1'b1;
         clear_addr_ff <= '0;
         first_char_ff <= mpb_pkg::CHAR_NUL;
      end else begin
         if (clear_busy_ff) begin
            if (clear_addr_ff == LAST_ADDR) begin
               clear_busy_ff <= 1'b0;
            end
            clear_addr_ff <= clear_addr_ff + 1'b1;
         end
         if (wr_en && wr_addr == '0) begin
            first_char_ff <= wr_data;
         end
      end
   end

   assign rd_data    = rd_data_ff;
   assign first_char = first_char_ff;
   assign clear_busy = clear_busy_ff;

endmodule

### rtl/core/mpb_sequencer.sv
// Tick divider, character and unit-slot sequencing, and per-unit lit decision.
module mpb_sequencer #(
   parameter int PHRASE_DEPTH = mpb_pkg::PHRASE_DEPTH_DEFAULT,
   parameter int ADDR_WIDTH   = $clog2(PHRASE_DEPTH)
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     go,
   input  logic [1:0]               req_kind,
   input  logic [15:0]              divider_period,
   input  logic [7:0]               next_char,
   input  logic [7:0]               first_char,
   output logic [ADDR_WIDTH-1:0]    rd_addr,
   output mpb_pkg::unit_type        unit
);

   localparam logic [ADDR_WIDTH:0] LAST_POS = (ADDR_WIDTH+1)'(PHRASE_DEPTH - 1);

   logic [15:0]           tick_div_ff, tick_div_in;
   logic [4:0]            unit_idx_ff, unit_idx_in;
   logic [ADDR_WIDTH-1:0] play_pos_ff, play_pos_in;
   logic                  ending_ff, ending_in;
   logic [7:0]            cur_char_ff, cur_char_in;

   logic                  marker;
   mpb_pkg::pattern_type  pat;
   logic [31:0]           pat_wide;
   logic                  unit_last;
   logic [ADDR_WIDTH:0]   next_pos;
   logic                  load_en;
   logic [ADDR_WIDTH-1:0] load_pos;
   logic [7:0]            load_char;

   assign marker    = ending_ff || cur_char_ff == mpb_pkg::CHAR_NUL;
   assign pat       = mpb_pkg::char_pattern(cur_char_ff, marker);
   assign pat_wide  = {{(32 - mpb_pkg::PATTERN_WIDTH){1'b0}}, pat.bits};
   assign unit_last = ({1'b0, unit_idx_ff} + 6'd1) >= {1'b0, pat.len};
   assign next_pos  = {1'b0, play_pos_ff} + 1'b1;

   // The memory always prefetches the character after the one in play.
   assign rd_addr = next_pos[ADDR_WIDTH-1:0];

   always_comb begin
      tick_div_in = tick_div_ff;
      unit_idx_in = unit_idx_ff;
      play_pos_in = play_pos_ff;
      ending_in   = ending_ff;
      cur_char_in = cur_char_ff;
      load_en     = 1'b0;
      load_pos    = '0;
      load_char   = first_char;
      unit.emit   = 1'b0;
      unit.lit    = pat_wide[unit_idx_ff];
      unit.marker = marker;

      if (go) begin
         priority if (req_kind == mpb_pkg::REQ_RESTART) begin
            tick_div_in = '0;
            load_en     = 1'b1;
         end else if (req_kind == mpb_pkg::REQ_TICK) begin
            if (tick_div_ff != divider_period) begin
               tick_div_in = tick_div_ff + 16'd1;
            end else begin
               tick_div_in = '0;
               unit.emit   = 1'b1;
               if (unit_last) begin
                  load_en = 1'b1;
                  if (!marker) begin
                     load_pos  = next_pos[ADDR_WIDTH-1:0];
                     load_char = (next_pos < LAST_POS) ? next_char : mpb_pkg::CHAR_NUL;
                  end
               end else begin
                  unit_idx_in = unit_idx_ff + 5'd1;
               end
            end
         end else begin
            tick_div_in = tick_div_ff;
         end
      end

      if (load_en) begin
         unit_idx_in = '0;
         if (load_char == mpb_pkg::CHAR_NUL) begin
            ending_in   = 1'b1;
            cur_char_in = mpb_pkg::CHAR_NUL;
            play_pos_in = '0;
         end else begin
            ending_in   = 1'b0;
            cur_char_in = load_char;
            play_pos_in = load_pos;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tick_div_ff <= '0;
         unit_idx_ff <= '0;
         play_pos_ff <= '0;
         ending_ff   <= 1'b0;
         cur_char_ff <= mpb_pkg::CHAR_NUL;
      end else begin
         tick_div_ff <= tick_div_in;
         unit_idx_ff <= unit_idx_in;
         play_pos_ff <= play_pos_in;
         ending_ff   <= ending_in;
         cur_char_ff <= cur_char_in;
      end
   end

endmodule

### rtl/core/morse_phrase_blinker_unit.sv
// Morse phrase blinker: one item per cycle unless a result is held or the sweep runs.
// Each accepted item is held in an input register and processed once the result register is
// free or drains; an emitting tick loads the result register, and a new item can be taken
// every cycle while results drain. After reset the whole phrase memory is swept to zero, req_ready low.
// Configuration registers and playback state clear on reset; the csr port is always ready.
`include "morse_phrase_blinker_unit_defines.svh"

module morse_phrase_blinker_unit #(
   parameter int PHRASE_DEPTH = mpb_pkg::PHRASE_DEPTH_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_type,
   input  logic [6:0]  req_char_index,
   input  logic [7:0]  req_char_code,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_led_number,
   output logic [23:0] rsp_color,
   output logic        rsp_lit,
   output logic        rsp_in_end_marker,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [23:0] csr_wdata
);

   localparam int ADDR_WIDTH = $clog2(PHRASE_DEPTH);

   logic [15:0] divider_period_ff;
   logic [7:0]  led_index_ff;
   logic [23:0] on_color_ff;
   logic [23:0] end_color_ff;

   logic        in_valid_ff, in_valid_in;
   logic [1:0]  req_type_ff;
   logic [6:0]  char_index_ff;
   logic [7:0]  char_code_ff;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [7:0]  rsp_led_ff;
   logic [23:0] rsp_color_ff;
   logic        rsp_lit_ff;
   logic        rsp_marker_ff;

   logic                  proc_go;
   logic                  in_take;
   logic                  wr_en;
   logic [ADDR_WIDTH-1:0] wr_addr;
   logic [ADDR_WIDTH-1:0] rd_addr;
   logic [7:0]            next_char;
   logic [7:0]            first_char;
   logic                  clear_busy;
   mpb_pkg::unit_type     unit;

   // The held item is processed whenever the result register is free or drains this cycle.
   assign proc_go   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !clear_busy && (!in_valid_ff || proc_go);
   assign in_take   = req_valid && req_ready;
   assign csr_ready = 1'b1;

   assign wr_en   = proc_go && req_type_ff == mpb_pkg::REQ_WRITE
                    && ({25'd0, char_index_ff} < 32'(PHRASE_DEPTH));
   assign wr_addr = ADDR_WIDTH'(char_index_ff);

   mpb_phrase_mem #(
      .PHRASE_DEPTH (PHRASE_DEPTH),
      .ADDR_WIDTH   (ADDR_WIDTH)
   ) u_phrase_mem (
      .clock      (clock),
      .reset      (reset),
      .wr_en      (wr_en),
      .wr_addr    (wr_addr),
      .wr_data    (char_code_ff),
      .rd_addr    (rd_addr),
      .rd_data    (next_char),
      .first_char (first_char),
      .clear_busy (clear_busy)
   );

   mpb_sequencer #(
      .PHRASE_DEPTH (PHRASE_DEPTH),
      .ADDR_WIDTH   (ADDR_WIDTH)
   ) u_sequencer (
      .clock          (clock),
      .reset          (reset),
      .go             (proc_go),
      .req_kind       (req_type_ff),
      .divider_period (divider_period_ff),
      .next_char      (next_char),
      .first_char     (first_char),
      .rd_addr        (rd_addr),
      .unit           (unit)
   );

   always_comb begin
      in_valid_in = in_valid_ff;
      if (in_take) begin
         in_valid_in = 1'b1;
      end else if (proc_go) begin
         in_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (proc_go && unit.emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff       <= 1'b0;
         rsp_valid_ff      <= 1'b0;
         divider_period_ff <= '0;
         led_index_ff      <= '0;
         on_color_ff       <= '0;
         end_color_ff      <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               mpb_pkg::CSR_DIVIDER_PERIOD: divider_period_ff <= csr_wdata[15:0];
               mpb_pkg::CSR_LED_INDEX:      led_index_ff      <= csr_wdata[7:0];
               mpb_pkg::CSR_ON_COLOR:       on_color_ff       <= csr_wdata;
               mpb_pkg::CSR_END_COLOR:      end_color_ff      <= csr_wdata;
               default:                     led_index_ff      <= led_index_ff;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (in_take) begin
         req_type_ff   <= req_type;
         char_index_ff <= req_char_index;
         char_code_ff  <= req_char_code;
      end
      if (proc_go && unit.emit) begin
         rsp_led_ff    <= led_index_ff;
         rsp_lit_ff    <= unit.lit;
         rsp_marker_ff <= unit.marker;
         if (unit.lit) begin
            rsp_color_ff <= unit.marker ? end_color_ff : on_color_ff;
         end else begin
            rsp_color_ff <= '0;
         end
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_led_number    = rsp_led_ff;
   assign rsp_color         = rsp_color_ff;
   assign rsp_lit           = rsp_lit_ff;
   assign rsp_in_end_marker = rsp_marker_ff;

   `MPB_ASSERT(a_emit_only_on_tick, clock, reset, proc_go && unit.emit |-> req_type_ff == mpb_pkg::REQ_TICK)
   `MPB_ASSERT(a_dark_unit_no_color, clock, reset, rsp_valid && !rsp_lit |-> rsp_color == 24'd0)
   `MPB_ASSERT(a_no_result_without_item, clock, reset, !in_valid_ff |=> !$rose(rsp_valid))
   `MPB_ASSERT_ALWAYS(a_sweep_blocks_input, clock, $fell(reset) |-> !req_ready)

endmodule
